[hdl/psc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg: shared constants of the permutation segment crossover unit
// Default sizes and the fixed field widths of the request and response beats.
// ----------------------------------------------------------------------------
package psc_pkg;

   // Default number of genes in one route and stored bits per gene.
   localparam int GENES_DEFAULT     = 8;
   localparam int GENE_BITS_DEFAULT = 8;

   // Fixed widths of the beat fields.
   localparam int GENE_FIELD_W   = 8;
   localparam int START_FIELD_W  = 4;
   localparam int LENGTH_FIELD_W = 3;

endpackage

[hdl/psc_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_req_if: request channel of the crossover unit
// Carries one gene position of both parents and the segment bounds per beat.
// ----------------------------------------------------------------------------
interface psc_req_if;
   import psc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [GENE_FIELD_W-1:0]   parent_a_gene;
   logic [GENE_FIELD_W-1:0]   parent_b_gene;
   logic [START_FIELD_W-1:0]  segment_start;
   logic [LENGTH_FIELD_W-1:0] segment_length;

   modport source (
      output valid, parent_a_gene, parent_b_gene, segment_start, segment_length,
      input  ready
   );

   modport sink (
      input  valid, parent_a_gene, parent_b_gene, segment_start, segment_length,
      output ready
   );
endinterface

[hdl/psc_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_rsp_if: response channel of the crossover unit
// Carries one child gene per beat and a flag on the final gene of the child.
// ----------------------------------------------------------------------------
interface psc_rsp_if;
   import psc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [GENE_FIELD_W-1:0] child_gene;
   logic                    last_child_gene;

   modport source (
      output valid, child_gene, last_child_gene,
      input  ready
   );

   modport sink (
      input  valid, child_gene, last_child_gene,
      output ready
   );
endinterface

[hdl/psc_parent_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_parent_store: gene memories of both parent routes
// One write port shared by both parents, one registered read port per parent.
// ----------------------------------------------------------------------------
module psc_parent_store #(
   parameter int GENES     = 8,
   parameter int GENE_BITS = 8,
   parameter int IDX_W     = $clog2(GENES)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  logic [GENE_BITS-1:0] wr_gene_a,
   input  logic [GENE_BITS-1:0] wr_gene_b,
   input  logic [IDX_W-1:0]     rd_addr_a,
   input  logic [IDX_W-1:0]     rd_addr_b,
   output logic [GENE_BITS-1:0] rd_gene_a,
   output logic [GENE_BITS-1:0] rd_gene_b
);

   logic [GENE_BITS-1:0] mem_a [GENES];
   logic [GENE_BITS-1:0] mem_b [GENES];
   logic [GENE_BITS-1:0] rd_a_ff;
   logic [GENE_BITS-1:0] rd_b_ff;

   // Parent A memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wr_addr] <= wr_gene_a;
      end
      rd_a_ff <= mem_a[rd_addr_a];
   end

   // Parent B memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_b[wr_addr] <= wr_gene_b;
      end
      rd_b_ff <= mem_b[rd_addr_b];
   end

   assign rd_gene_a = rd_a_ff;
   assign rd_gene_b = rd_b_ff;

endmodule

[hdl/permutation_segment_crossover_unit.sv]
`timescale 1ns / 1ps
// Load: the beat of the final position starts the build.
// Build: each head or tail gene of parent A is checked against the segment genes of B,
// one shared compare per segment gene; a segment gene of B is pushed as is; then a flush.
// A push or the flush waits while the result register is still held by the sink.
// Input: new parents are taken only in the load state, after the last child is flushed.
// Reset: synchronous, active high; clears sequencer, load position and valid, not memories.
// ----------------------------------------------------------------------------
// permutation_segment_crossover_unit: segment-preserving order crossover
// Loads two parent routes one position per beat, then streams the child route.
// ----------------------------------------------------------------------------
module permutation_segment_crossover_unit #(
   parameter int GENES     = psc_pkg::GENES_DEFAULT,
   parameter int GENE_BITS = psc_pkg::GENE_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   psc_req_if.sink   req_chan,
   psc_rsp_if.source rsp_chan
);
   import psc_pkg::*;

   localparam int IDX_W = $clog2(GENES);
   localparam int CNT_W = $clog2(GENES + 1);
   localparam int POS_W = (CNT_W > START_FIELD_W) ? CNT_W : START_FIELD_W;

   typedef enum logic [3:0] {
      S_LOAD,
      S_NEXT,
      S_A_READ,
      S_A_LATCH,
      S_B_READ,
      S_B_CMP,
      S_SEG_READ,
      S_SEG_TAKE,
      S_PUSH,
      S_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      P_HEAD,
      P_SEG,
      P_TAIL
   } phase_type;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [IDX_W-1:0]     load_pos_ff, load_pos_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     seg_ff, seg_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [GENE_BITS-1:0] gene_ff, gene_in;
   logic [GENE_BITS-1:0] pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [GENE_FIELD_W-1:0] rsp_gene_ff, rsp_gene_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_ready;
   logic                 req_take;
   logic                 out_free;
   logic                 store_wr;
   logic [IDX_W-1:0]     rd_addr_b;
   logic [GENE_BITS-1:0] rd_gene_a;
   logic [GENE_BITS-1:0] rd_gene_b;

   logic [POS_W-1:0]     start_w;
   logic [POS_W-1:0]     lo_w;
   logic [POS_W-1:0]     room_w;
   logic [POS_W-1:0]     len_w;
   logic [POS_W-1:0]     hi_w;

   // Handshake terms.
   assign req_ready = (state_ff == S_LOAD);
   assign req_take  = req_chan.valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign store_wr  = req_take;
   assign rd_addr_b = (state_ff == S_SEG_READ) ? pos_ff[IDX_W-1:0] : seg_ff[IDX_W-1:0];

   // Parent memories.
   psc_parent_store #(
      .GENES     (GENES),
      .GENE_BITS (GENE_BITS),
      .IDX_W     (IDX_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (store_wr),
      .wr_addr   (load_pos_ff),
      .wr_gene_a (GENE_BITS'(req_chan.parent_a_gene)),
      .wr_gene_b (GENE_BITS'(req_chan.parent_b_gene)),
      .rd_addr_a (pos_ff[IDX_W-1:0]),
      .rd_addr_b (rd_addr_b),
      .rd_gene_a (rd_gene_a),
      .rd_gene_b (rd_gene_b)
   );

   // Segment bounds: clamp the start into 1..GENES and the end to GENES.
   always_comb begin
      start_w = POS_W'(req_chan.segment_start);
      if (start_w == '0) begin
         start_w = POS_W'(1);
      end
      if (start_w > POS_W'(GENES)) begin
         start_w = POS_W'(GENES);
      end
      lo_w   = start_w - POS_W'(1);
      room_w = POS_W'(GENES) - lo_w;
      len_w  = POS_W'(req_chan.segment_length);
      if (len_w > room_w) begin
         len_w = room_w;
      end
      hi_w = lo_w + len_w;
   end

   // Sequencer: walks the head of A, the segment of B and the tail of A.
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      load_pos_in   = load_pos_ff;
      pos_in        = pos_ff;
      seg_in        = seg_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      count_in      = count_ff;
      gene_in       = gene_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_gene_in   = rsp_gene_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_LOAD: begin
            if (req_take) begin
               if (load_pos_ff == IDX_W'(GENES - 1)) begin
                  load_pos_in   = '0;
                  lo_in         = CNT_W'(lo_w);
                  hi_in         = CNT_W'(hi_w);
                  phase_in      = P_HEAD;
                  pos_in        = '0;
                  count_in      = '0;
                  pend_valid_in = 1'b0;
                  state_in      = S_NEXT;
               end else begin
                  load_pos_in = load_pos_ff + IDX_W'(1);
               end
            end
         end

         // Pick the next gene source or move on to the next run.
         S_NEXT: begin
            case (phase_ff)
               P_HEAD: begin
                  if (pos_ff == lo_ff) begin
                     phase_in = P_SEG;
                  end else begin
                     state_in = S_A_READ;
                  end
               end
               P_SEG: begin
                  if (pos_ff == hi_ff) begin
                     phase_in = P_TAIL;
                     pos_in   = lo_ff;
                  end else begin
                     state_in = S_SEG_READ;
                  end
               end
               default: begin
                  if (pos_ff == CNT_W'(GENES)) begin
                     state_in = S_FLUSH;
                  end else begin
                     state_in = S_A_READ;
                  end
               end
            endcase
         end

         S_A_READ: begin
            state_in = S_A_LATCH;
         end

         // Hold the gene of A and start the scan of the segment.
         S_A_LATCH: begin
            gene_in = rd_gene_a;
            seg_in  = lo_ff;
            if (lo_ff == hi_ff) begin
               state_in = S_PUSH;
            end else begin
               state_in = S_B_READ;
            end
         end

         S_B_READ: begin
            state_in = S_B_CMP;
         end

         // One shared compare per segment gene; a hit drops the gene of A.
         S_B_CMP: begin
            if (rd_gene_b == gene_ff) begin
               pos_in   = pos_ff + CNT_W'(1);
               state_in = S_NEXT;
            end else if (seg_ff + CNT_W'(1) == hi_ff) begin
               state_in = S_PUSH;
            end else begin
               seg_in   = seg_ff + CNT_W'(1);
               state_in = S_B_READ;
            end
         end

         S_SEG_READ: begin
            state_in = S_SEG_TAKE;
         end

         S_SEG_TAKE: begin
            gene_in  = rd_gene_b;
            state_in = S_PUSH;
         end

         // The held gene goes out once its successor is known.
         S_PUSH: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_gene_in  = GENE_FIELD_W'(pend_ff);
                  rsp_last_in  = 1'b0;
               end
               pend_in       = gene_ff;
               pend_valid_in = 1'b1;
               count_in      = count_ff + CNT_W'(1);
               pos_in        = pos_ff + CNT_W'(1);
               if (count_ff == CNT_W'(GENES - 1)) begin
                  state_in = S_FLUSH;
               end else begin
                  state_in = S_NEXT;
               end
            end
         end

         // The held gene is the final one of the child.
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_LOAD;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_gene_in   = GENE_FIELD_W'(pend_ff);
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_LOAD;
            end
         end

         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         phase_ff      <= P_HEAD;
         load_pos_ff   <= '0;
         pos_ff        <= '0;
         seg_ff        <= '0;
         lo_ff         <= '0;
         hi_ff         <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         load_pos_ff   <= load_pos_in;
         pos_ff        <= pos_in;
         seg_ff        <= seg_in;
         lo_ff         <= lo_in;
         hi_ff         <= hi_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      gene_ff     <= gene_in;
      pend_ff     <= pend_in;
      rsp_gene_ff <= rsp_gene_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Port drive.
   assign req_chan.ready           = req_ready;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.child_gene      = rsp_gene_ff;
   assign rsp_chan.last_child_gene = rsp_last_ff;

endmodule
